FILE: sv/q2e_pkg.sv
`default_nettype none
package q2e_pkg;

    localparam int AW     = 34;
    localparam int ANG_W  = 34;
    localparam int SQ_W   = 61;
    localparam int ROOT_W = 31;
    localparam int RND_W  = 18;

    localparam logic signed [AW-1:0]    Q30_ONE = 34'sd1073741824;
    localparam logic signed [ANG_W-1:0] HALF_PI = 34'sd1073741824;

    typedef logic signed [15:0]   t_q15;
    typedef logic signed [AW-1:0] t_vec;

    typedef struct packed {
        t_q15 q_w;
        t_q15 q_x;
        t_q15 q_y;
        t_q15 q_z;
    } t_quat;

    typedef struct packed {
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
        logic signed [15:0] yaw_angle;
        logic               pitch_clamped;
    } t_euler;

    typedef struct packed {
        logic               clamped;
        logic signed [31:0] s;
        t_vec               roll_y;
        t_vec               roll_x;
        t_vec               yaw_y;
        t_vec               yaw_x;
    } t_side;

    typedef struct packed {
        logic en;
        logic vld;
    } t_pctl;

    // atan(2^-i) in units of pi/2^31
    function automatic logic [31:0] atan_unit(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            5'd24:   r = 32'h00000029;
            5'd25:   r = 32'h00000014;
            5'd26:   r = 32'h0000000A;
            5'd27:   r = 32'h00000005;
            5'd28:   r = 32'h00000003;
            5'd29:   r = 32'h00000001;
            5'd30:   r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/q2e_front.sv
`default_nettype none
module q2e_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire q2e_pkg::t_pctl         i_ctl,
    input  wire q2e_pkg::t_quat         i_quat,
    output logic                        o_vld,
    output logic [q2e_pkg::SQ_W-1:0]    o_v,
    output q2e_pkg::t_side              o_side
);

    logic [3:0] r_vld;

    logic signed [31:0] r_wy, r_xz, r_yz, r_wx, r_xx, r_yy, r_xy, r_wz, r_ww, r_zz;

    logic signed [q2e_pkg::AW-1:0] s_raw;
    logic signed [31:0]            s_sat;
    logic                          s_clp;
    q2e_pkg::t_side                n_side2;
    q2e_pkg::t_side                r_side2, r_side3, r_side4;
    logic [30:0]                   s_mag;
    logic [q2e_pkg::SQ_W-1:0]      sq;
    logic [q2e_pkg::SQ_W-1:0]      r_sq, r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[2:0], i_ctl.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_wy <= 32'(i_quat.q_w) * 32'(i_quat.q_y);
            r_xz <= 32'(i_quat.q_x) * 32'(i_quat.q_z);
            r_yz <= 32'(i_quat.q_y) * 32'(i_quat.q_z);
            r_wx <= 32'(i_quat.q_w) * 32'(i_quat.q_x);
            r_xx <= 32'(i_quat.q_x) * 32'(i_quat.q_x);
            r_yy <= 32'(i_quat.q_y) * 32'(i_quat.q_y);
            r_xy <= 32'(i_quat.q_x) * 32'(i_quat.q_y);
            r_wz <= 32'(i_quat.q_w) * 32'(i_quat.q_z);
            r_ww <= 32'(i_quat.q_w) * 32'(i_quat.q_w);
            r_zz <= 32'(i_quat.q_z) * 32'(i_quat.q_z);
        end
    end

    always_comb begin
        s_raw = (34'(r_wy) - 34'(r_xz)) <<< 1;
        s_clp = 1'b0;
        if (s_raw > q2e_pkg::Q30_ONE) begin
            s_sat = 32'(q2e_pkg::Q30_ONE);
            s_clp = 1'b1;
        end else if (s_raw < -q2e_pkg::Q30_ONE) begin
            s_sat = 32'(-q2e_pkg::Q30_ONE);
            s_clp = 1'b1;
        end else begin
            s_sat = 32'(s_raw);
        end
        n_side2.clamped = s_clp;
        n_side2.s       = s_sat;
        n_side2.roll_y  = (34'(r_yz) + 34'(r_wx)) <<< 1;
        n_side2.roll_x  = q2e_pkg::Q30_ONE - (34'(r_xx) <<< 1) - (34'(r_yy) <<< 1);
        n_side2.yaw_y   = (34'(r_xy) + 34'(r_wz)) <<< 1;
        n_side2.yaw_x   = 34'(r_ww) + 34'(r_xx) - 34'(r_yy) - 34'(r_zz);
    end

    assign s_mag = 31'(r_side2.s[31] ? -r_side2.s : r_side2.s);
    assign sq    = 61'(s_mag) * 61'(s_mag);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_side2 <= n_side2;
            r_side3 <= r_side2;
            r_sq    <= sq;
            r_side4 <= r_side3;
            r_v     <= {1'b1, 60'd0} - r_sq;
        end
    end

    assign o_vld  = r_vld[3];
    assign o_v    = r_v;
    assign o_side = r_side4;

endmodule
`default_nettype wire

FILE: sv/q2e_sqrt.sv
`default_nettype none
module q2e_sqrt (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire q2e_pkg::t_pctl          i_ctl,
    input  wire logic [q2e_pkg::SQ_W-1:0] i_v,
    input  wire q2e_pkg::t_side          i_side,
    output logic                         o_vld,
    output logic [q2e_pkg::ROOT_W-1:0]   o_root,
    output q2e_pkg::t_side               o_side
);

    localparam int NST = q2e_pkg::ROOT_W;

    logic [q2e_pkg::SQ_W-1:0] r_rem  [NST];
    logic [q2e_pkg::SQ_W:0]   r_res  [NST];
    q2e_pkg::t_side           r_side [NST];
    logic [NST-1:0]           r_vld;

    for (genvar k = 0; k < NST; k++) begin : g_st
        localparam logic [q2e_pkg::SQ_W:0] BIT = 62'd1 << (2 * (NST - 1 - k));
        logic [q2e_pkg::SQ_W-1:0] rem_in;
        logic [q2e_pkg::SQ_W:0]   res_in, trial;
        q2e_pkg::t_side           side_in;
        logic                     vld_in, take;

        if (k == 0) begin : g_first
            assign rem_in  = i_v;
            assign res_in  = '0;
            assign side_in = i_side;
            assign vld_in  = i_ctl.vld;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign res_in  = r_res[k-1];
            assign side_in = r_side[k-1];
            assign vld_in  = r_vld[k-1];
        end

        assign trial = res_in + BIT;
        assign take  = {1'b0, rem_in} >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_side[k] <= side_in;
                if (take) begin
                    r_rem[k] <= rem_in - trial[q2e_pkg::SQ_W-1:0];
                    r_res[k] <= (res_in >> 1) + BIT;
                end else begin
                    r_rem[k] <= rem_in;
                    r_res[k] <= res_in >> 1;
                end
            end
        end
    end

    assign o_vld  = r_vld[NST-1];
    assign o_root = r_res[NST-1][q2e_pkg::ROOT_W-1:0];
    assign o_side = r_side[NST-1];

endmodule
`default_nettype wire

FILE: sv/q2e_cordic.sv
`default_nettype none
module q2e_cordic #(
    parameter int DATA_WIDTH   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire q2e_pkg::t_vec                    i_y,
    input  wire q2e_pkg::t_vec                    i_x,
    output logic signed [q2e_pkg::RND_W-1:0]      o_angle
);

    localparam int CW = DATA_WIDTH + 2;
    localparam int AW = q2e_pkg::AW;
    localparam int ZW = q2e_pkg::ANG_W;
    localparam logic [5:0] NORM = 6'(DATA_WIDTH - 3);

    // leading-one search on max magnitude
    logic signed [AW:0] xe, ye;
    logic [AW:0]        ax, ay, m;
    logic [5:0]         pos;

    q2e_pkg::t_vec r_xa, r_ya;
    logic [5:0]    r_pos;
    logic          r_zero_a;

    assign xe = (AW+1)'(i_x);
    assign ye = (AW+1)'(i_y);
    assign ax = xe[AW] ? -xe : xe;
    assign ay = ye[AW] ? -ye : ye;
    assign m  = (ax > ay) ? ax : ay;

    always_comb begin
        pos = '0;
        for (int j = 0; j <= AW; j++) begin
            if (m[j]) begin
                pos = 6'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xa     <= i_x;
            r_ya     <= i_y;
            r_pos    <= pos;
            r_zero_a <= (m == '0);
        end
    end

    // normalise, then fold the left half plane
    logic signed [CW-1:0] xn, yn, n_x0, n_y0;
    logic signed [ZW-1:0] n_z0;
    logic [5:0]           sh;

    always_comb begin
        if (r_pos >= NORM) begin
            sh = r_pos - NORM;
            xn = CW'(r_xa >>> sh);
            yn = CW'(r_ya >>> sh);
        end else begin
            sh = NORM - r_pos;
            xn = CW'(r_xa) <<< sh;
            yn = CW'(r_ya) <<< sh;
        end
        if (xn[CW-1]) begin
            if (!yn[CW-1]) begin
                n_x0 = yn;
                n_y0 = -xn;
                n_z0 = q2e_pkg::HALF_PI;
            end else begin
                n_x0 = -yn;
                n_y0 = xn;
                n_z0 = -q2e_pkg::HALF_PI;
            end
        end else begin
            n_x0 = xn;
            n_y0 = yn;
            n_z0 = '0;
        end
    end

    logic signed [CW-1:0] r_x0, r_y0;
    logic signed [ZW-1:0] r_z0;
    logic                 r_zero0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x0    <= n_x0;
            r_y0    <= n_y0;
            r_z0    <= n_z0;
            r_zero0 <= r_zero_a;
        end
    end

    logic signed [CW-1:0] r_x  [CORDIC_STEPS];
    logic signed [CW-1:0] r_y  [CORDIC_STEPS];
    logic signed [ZW-1:0] r_z  [CORDIC_STEPS];
    logic                 r_zf [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
        localparam logic signed [ZW-1:0] ATN = $signed(ZW'(q2e_pkg::atan_unit(5'(i))));
        logic signed [CW-1:0] x_in, y_in, xs, ys;
        logic signed [ZW-1:0] z_in;
        logic                 zf_in;

        if (i == 0) begin : g_first
            assign x_in  = r_x0;
            assign y_in  = r_y0;
            assign z_in  = r_z0;
            assign zf_in = r_zero0;
        end else begin : g_next
            assign x_in  = r_x[i-1];
            assign y_in  = r_y[i-1];
            assign z_in  = r_z[i-1];
            assign zf_in = r_zf[i-1];
        end

        assign xs = x_in >>> i;
        assign ys = y_in >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zf[i] <= zf_in;
                if (!y_in[CW-1]) begin
                    r_x[i] <= x_in + ys;
                    r_y[i] <= y_in - xs;
                    r_z[i] <= z_in + ATN;
                end else begin
                    r_x[i] <= x_in - ys;
                    r_y[i] <= y_in + xs;
                    r_z[i] <= z_in - ATN;
                end
            end
        end
    end

    logic signed [ZW-1:0]              z_rnd;
    logic signed [q2e_pkg::RND_W-1:0]  r_ang;

    assign z_rnd = r_z[CORDIC_STEPS-1] + 34'sd32768;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= r_zf[CORDIC_STEPS-1] ? '0 : z_rnd[ZW-1:16];
        end
    end

    assign o_angle = r_ang;

endmodule
`default_nettype wire

FILE: sv/quaternion_to_euler_angles.sv
`default_nettype none
// channel  direction  handshake              beat
// input    in         i_valid / o_stall      i_data (q_w, q_x, q_y, q_z)
// output   out        o_valid / i_stall      o_data (pitch, roll, yaw, clamped)
//
// One beat per cycle while the output is not stalled; the pipe has 4 product/sum stages,
// 31 square-root stages, 2 normalise stages, CORDIC_STEPS iterations and 1 round stage.
// Reset clears the valid bits only.
// A stalled output beat freezes the whole pipe; o_stall follows it.
module quaternion_to_euler_angles #(
    parameter int DATA_WIDTH   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire q2e_pkg::t_quat  i_data,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output q2e_pkg::t_euler      o_data
);

    localparam int LAT = CORDIC_STEPS + 3;

    logic                             en;
    q2e_pkg::t_pctl                   f_ctl, s_ctl;
    logic                             f_vld, s_vld;
    logic [q2e_pkg::SQ_W-1:0]         f_v;
    q2e_pkg::t_side                   f_side, s_side;
    logic [q2e_pkg::ROOT_W-1:0]       root;
    logic signed [q2e_pkg::RND_W-1:0] p_ang, r_ang, y_ang;
    logic [LAT-1:0]                   r_vld_d, r_clp_d;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    assign f_ctl.en  = en;
    assign f_ctl.vld = i_valid;
    assign s_ctl.en  = en;
    assign s_ctl.vld = f_vld;

    q2e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (f_ctl),
        .i_quat  (i_data),
        .o_vld   (f_vld),
        .o_v     (f_v),
        .o_side  (f_side)
    );

    q2e_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s_ctl),
        .i_v     (f_v),
        .i_side  (f_side),
        .o_vld   (s_vld),
        .o_root  (root),
        .o_side  (s_side)
    );

    q2e_cordic #(.DATA_WIDTH(DATA_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (q2e_pkg::AW'(s_side.s)),
        .i_x     (q2e_pkg::AW'(root)),
        .o_angle (p_ang)
    );

    q2e_cordic #(.DATA_WIDTH(DATA_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (s_side.roll_y),
        .i_x     (s_side.roll_x),
        .o_angle (r_ang)
    );

    q2e_cordic #(.DATA_WIDTH(DATA_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (s_side.yaw_y),
        .i_x     (s_side.yaw_x),
        .o_angle (y_ang)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_d <= '0;
        end else if (en) begin
            r_vld_d <= {r_vld_d[LAT-2:0], s_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_clp_d <= {r_clp_d[LAT-2:0], s_side.clamped};
        end
    end

    always_comb begin
        if (p_ang > 18'sd16384) begin
            o_data.pitch_angle = 16'sd16384;
        end else if (p_ang < -18'sd16384) begin
            o_data.pitch_angle = -16'sd16384;
        end else begin
            o_data.pitch_angle = p_ang[15:0];
        end
        o_data.roll_angle    = r_ang[15:0];
        o_data.yaw_angle     = y_ang[15:0];
        o_data.pitch_clamped = r_clp_d[LAT-1];
    end

    assign o_valid = r_vld_d[LAT-1];

    a_pitch_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.pitch_angle <= 16'sd16384 && o_data.pitch_angle >= -16'sd16384))
        else $error("pitch out of range");

    a_reset_idle : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled beat changed");

endmodule
`default_nettype wire
